// File: rtl/hgs_pkg.sv
// ----------------------------------------------------------------------------
// hgs_pkg: haptic gain scheduler package
// Field widths, register indexes and the fixed-point constants of the gain
// schedule, with the reciprocals used for the three constant divisions.
// ----------------------------------------------------------------------------
package hgs_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned STR_W      = 16;
  localparam int unsigned WID_W      = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned MICROS_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETENT_STRENGTH  = 3'd0,
    CFG_ENDSTOP_STRENGTH = 3'd1,
    CFG_DETENT_WIDTH     = 3'd2,
    CFG_HAS_LISTED       = 3'd3,
    CFG_SCALE_PROP       = 3'd4,
    CFG_SCALE_INTEG      = 3'd5,
    CFG_SCALE_DERIV      = 3'd6
  } cfg_idx_e;

  localparam int unsigned FADE_START_SPEED = 2560;
  localparam int unsigned FADE_END_SPEED   = 5120;
  localparam int unsigned INTEGRAL_BASE    = 256;

  localparam int unsigned W_DAMP_LO = 429;
  localparam int unsigned W_DAMP_HI = 1144;
  localparam int unsigned W_CLICK   = 1430;
  localparam int unsigned COEF_LO   = 5243;
  localparam int unsigned COEF_HI   = 1311;
  localparam int unsigned BAND_FRAC = 19661;
  localparam int unsigned BAND_MAX  = 429;
  localparam int unsigned CLICK_US  = 3000;
  localparam int unsigned SCALE_ONE = 4096;

  // fade is Q1.16 in 0..65536
  localparam int unsigned FADE_W   = 17;
  localparam int unsigned FADE_Q_W = 16;
  localparam int unsigned FADE_ONE = 65536;
  localparam int unsigned FADE_X_W = 16;

  // floor(x * 2^16 / span) for x < span as (x * recip) >> (K - 16)
  localparam int unsigned FADE_SPAN = (FADE_END_SPEED > FADE_START_SPEED) ?
                                      FADE_END_SPEED - FADE_START_SPEED : 1;
  localparam int unsigned FADE_LG      = $clog2(FADE_SPAN);
  localparam int unsigned FADE_K       = 16 + 2 * FADE_LG;
  localparam int unsigned FADE_RECIP_W = 18 + FADE_LG;
  localparam longint unsigned FADE_RECIP =
    ((64'd1 << FADE_K) + 64'(FADE_SPAN) - 64'd1) / 64'(FADE_SPAN);
  localparam int unsigned FADE_P_W = FADE_X_W + FADE_RECIP_W;

  // damping coefficient: COEF_LO - floor(COEF_DROP * y / DAMP_SPAN)
  localparam int unsigned DAMP_SPAN    = W_DAMP_HI - W_DAMP_LO;
  localparam int unsigned COEF_DROP    = COEF_LO - COEF_HI;
  localparam int unsigned DAMP_W       = $clog2(DAMP_SPAN);
  localparam int unsigned COEF_N_W     = $clog2(COEF_DROP * DAMP_SPAN);
  localparam int unsigned COEF_K       = COEF_N_W + $clog2(DAMP_SPAN);
  localparam int unsigned COEF_RECIP_W = COEF_N_W + 2;
  localparam longint unsigned COEF_RECIP =
    ((64'd1 << COEF_K) + 64'(DAMP_SPAN) - 64'd1) / 64'(DAMP_SPAN);
  localparam int unsigned COEF_P_W = COEF_N_W + COEF_RECIP_W;
  localparam int unsigned COEF_Q_W = $clog2(COEF_DROP + 1);
  localparam int unsigned COEF_W   = $clog2(COEF_LO + 1);

  // click taper: floor((W_CLICK - w) * 2^16 / W_CLICK)
  localparam int unsigned TAPER_X_W     = $clog2(W_CLICK + 1);
  localparam int unsigned TAPER_LG      = $clog2(W_CLICK);
  localparam int unsigned TAPER_K       = 16 + 2 * TAPER_LG;
  localparam int unsigned TAPER_RECIP_W = 18 + TAPER_LG;
  localparam longint unsigned TAPER_RECIP =
    ((64'd1 << TAPER_K) + 64'(W_CLICK) - 64'd1) / 64'(W_CLICK);
  localparam int unsigned TAPER_P_W = TAPER_X_W + TAPER_RECIP_W;
  localparam int unsigned TAPER_W   = 17;

  localparam int unsigned PROD_W  = STR_W + SCALE_W;
  localparam int unsigned INTEG_W = PROD_W + 16 - 12;
  localparam int unsigned DT_W    = STR_W + TAPER_W;
  localparam int unsigned CF_W    = COEF_W + FADE_W;

endpackage

// File: rtl/hgs_in_if.sv
// ----------------------------------------------------------------------------
// hgs_in_if: velocity sample channel
// Valid/ready channel carrying one knob sample and its two spring flags.
// ----------------------------------------------------------------------------
interface hgs_in_if
  import hgs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic signed [VEL_W-1:0] knob_velocity;
  logic               detent_engaged;
  logic               beyond_bounds;

  modport source (output valid, output knob_velocity, output detent_engaged,
                  output beyond_bounds, input ready);
  modport sink   (input valid, input knob_velocity, input detent_engaged,
                  input beyond_bounds, output ready);
endinterface

// File: rtl/hgs_out_if.sv
// ----------------------------------------------------------------------------
// hgs_out_if: gain result channel
// Valid/ready channel carrying the loop gains, integral band and click burst.
// ----------------------------------------------------------------------------
interface hgs_out_if
  import hgs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [GAIN_W-1:0]   gain_prop;
  logic [GAIN_W-1:0]   gain_integ;
  logic [GAIN_W-1:0]   gain_deriv;
  logic [BAND_W-1:0]   integ_band;
  logic [GAIN_W-1:0]   burst_torque;
  logic [MICROS_W-1:0] click_micros;

  modport source (output valid, output gain_prop, output gain_integ,
                  output gain_deriv, output integ_band, output burst_torque,
                  output click_micros, input ready);
  modport sink   (input valid, input gain_prop, input gain_integ,
                  input gain_deriv, input integ_band, input burst_torque,
                  input click_micros, output ready);
endinterface

// File: rtl/haptic_gain_scheduler.sv
// ----------------------------------------------------------------------------
// haptic_gain_scheduler: position-loop gain schedule for a haptic knob
// Four-stage pipeline turning each velocity request into faded PID gains,
// integral band and click burst from the configured detent settings.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the output is not stalled; its
// result is registered at each stage of the multiplier chain (strength by
// scale, by fade, by damping) and reaches the output register last. A stall
// on the output holds every stage in place, and the input is ready whenever
// the output register is empty or being emptied. Registers are to be written
// only while the pipeline is empty.
module haptic_gain_scheduler
  import hgs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hgs_in_if.sink                req_i,
  hgs_out_if.source             rsp_o
);

  logic [STR_W-1:0]   det_str_q, end_str_q;
  logic [WID_W-1:0]   det_width_q;
  logic               has_listed_q;
  logic [SCALE_W-1:0] scale_prop_q, scale_integ_q, scale_deriv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_str_q     <= '0;
      end_str_q     <= '0;
      det_width_q   <= '0;
      has_listed_q  <= 1'b0;
      scale_prop_q  <= SCALE_W'(SCALE_ONE);
      scale_integ_q <= SCALE_W'(SCALE_ONE);
      scale_deriv_q <= SCALE_W'(SCALE_ONE);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DETENT_STRENGTH:  det_str_q     <= cfg_data_i;
        CFG_ENDSTOP_STRENGTH: end_str_q     <= cfg_data_i;
        CFG_DETENT_WIDTH:     det_width_q   <= cfg_data_i;
        CFG_HAS_LISTED:       has_listed_q  <= cfg_data_i[0];
        CFG_SCALE_PROP:       scale_prop_q  <= cfg_data_i;
        CFG_SCALE_INTEG:      scale_integ_q <= cfg_data_i;
        CFG_SCALE_DERIV:      scale_deriv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  assign adv         = !v4_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: speed, strength products, damping numerator, click taper
  logic [VEL_W-1:0]     vel_u, speed1_d, speed1_q;
  logic [STR_W-1:0]     str_sel;
  logic [PROD_W-1:0]    sp_prod1_d, sp_prod1_q, dsd1_d, dsd1_q, dsi1_d, dsi1_q;
  logic [DAMP_W-1:0]    damp_y;
  logic [COEF_N_W-1:0]  coefn1_d, coefn1_q;
  logic [TAPER_X_W-1:0] taper_x;
  logic [TAPER_P_W-1:0] taper_prod;
  logic [TAPER_W-1:0]   taper1_d, taper1_q;
  logic                 spring1_q, oob1_q;

  assign vel_u      = req_i.knob_velocity;
  assign speed1_d   = vel_u[VEL_W-1] ? VEL_W'(~vel_u + 1'b1) : vel_u;
  assign str_sel    = req_i.beyond_bounds ? end_str_q : det_str_q;
  assign sp_prod1_d = PROD_W'(str_sel) * PROD_W'(scale_prop_q);
  assign dsd1_d     = PROD_W'(det_str_q) * PROD_W'(scale_deriv_q);
  assign dsi1_d     = PROD_W'(det_str_q) * PROD_W'(scale_integ_q);
  assign damp_y     = DAMP_W'(det_width_q - WID_W'(W_DAMP_LO));
  assign coefn1_d   = COEF_N_W'(damp_y) * COEF_N_W'(COEF_DROP);
  assign taper_x    = TAPER_X_W'(WID_W'(W_CLICK) - det_width_q);
  assign taper_prod = TAPER_P_W'(taper_x) * TAPER_P_W'(TAPER_RECIP);
  assign taper1_d   = taper_prod[TAPER_K-16 +: TAPER_W];

  // stage 2: fade, damping coefficient, integral base product
  logic [FADE_X_W-1:0]  fade_x;
  logic [FADE_P_W-1:0]  fade_prod;
  logic [FADE_W-1:0]    fade2_d, fade2_q;
  logic [COEF_P_W-1:0]  coef_prod;
  logic [COEF_W-1:0]    coef2_d, coef2_q;
  logic [PROD_W+16-1:0] ib_prod;
  logic [INTEG_W-1:0]   it2_q;
  logic [DT_W-1:0]      dt2_d, dt2_q;
  logic [PROD_W-1:0]    sp_prod2_q, dsd2_q;
  logic                 spring2_q, oob2_q;

  assign fade_x    = FADE_X_W'(FADE_END_SPEED) - speed1_q;
  assign fade_prod = FADE_P_W'(fade_x) * FADE_P_W'(FADE_RECIP);
  assign coef_prod = COEF_P_W'(coefn1_q) * COEF_P_W'(COEF_RECIP);
  assign ib_prod   = (PROD_W+16)'(dsi1_q) * (PROD_W+16)'(INTEGRAL_BASE);
  assign dt2_d     = DT_W'(det_str_q) * DT_W'(taper1_q);

  always_comb begin
    if (speed1_q <= VEL_W'(FADE_START_SPEED)) begin
      fade2_d = FADE_W'(FADE_ONE);
    end else if (speed1_q >= VEL_W'(FADE_END_SPEED)) begin
      fade2_d = '0;
    end else begin
      fade2_d = FADE_W'(fade_prod[FADE_K-16 +: FADE_Q_W]);
    end
    if (det_width_q <= WID_W'(W_DAMP_LO)) begin
      coef2_d = COEF_W'(COEF_LO);
    end else if (det_width_q >= WID_W'(W_DAMP_HI)) begin
      coef2_d = COEF_W'(COEF_HI);
    end else begin
      coef2_d = COEF_W'(COEF_LO) - COEF_W'(coef_prod[COEF_K +: COEF_Q_W]);
    end
  end

  // stage 3: multiply by fade, clamp the integral band
  logic [PROD_W+FADE_W-1:0]  prop_full;
  logic [INTEG_W+FADE_W-1:0] integ_full;
  logic [DT_W+FADE_W-1:0]    click_full;
  logic [GAIN_W-1:0]         prop3_q, integ3_d, integ3_q, click3_q;
  logic [CF_W-1:0]           cf3_q;
  logic [PROD_W-1:0]         dsd3_q;
  logic [30:0]               band_prod;
  logic [BAND_W-1:0]         band_raw, band3_d, band3_q;
  logic                      live3_q, oob3_q;

  assign prop_full  = (PROD_W+FADE_W)'(sp_prod2_q) * (PROD_W+FADE_W)'(fade2_q);
  assign integ_full = (INTEG_W+FADE_W)'(it2_q) * (INTEG_W+FADE_W)'(fade2_q);
  assign click_full = (DT_W+FADE_W)'(dt2_q) * (DT_W+FADE_W)'(fade2_q);
  assign band_prod  = 31'(det_width_q) * 31'(BAND_FRAC);
  assign band_raw   = BAND_W'(band_prod[30:16]);
  assign band3_d    = (band_raw < BAND_W'(BAND_MAX)) ? band_raw : BAND_W'(BAND_MAX);
  assign integ3_d   = (|integ_full[INTEG_W+FADE_W-1:GAIN_W+16]) ? '1 :
                      integ_full[GAIN_W+16-1:16];

  // stage 4: damping product and gating into the output register
  logic [PROD_W+CF_W-1:0] deriv_full;
  logic                   inb4, click_ok;

  assign deriv_full = (PROD_W+CF_W)'(dsd3_q) * (PROD_W+CF_W)'(cf3_q);
  assign inb4       = live3_q && !oob3_q;
  assign click_ok   = inb4 && !has_listed_q && (det_width_q < WID_W'(W_CLICK));

  logic [GAIN_W-1:0]   gp_q, gi_q, gd_q, ct_q;
  logic [BAND_W-1:0]   band_q;
  logic [MICROS_W-1:0] cm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      speed1_q   <= speed1_d;
      spring1_q  <= req_i.detent_engaged;
      oob1_q     <= req_i.beyond_bounds;
      sp_prod1_q <= sp_prod1_d;
      dsd1_q     <= dsd1_d;
      dsi1_q     <= dsi1_d;
      coefn1_q   <= coefn1_d;
      taper1_q   <= taper1_d;

      fade2_q    <= fade2_d;
      coef2_q    <= coef2_d;
      it2_q      <= ib_prod[PROD_W+16-1:12];
      dt2_q      <= dt2_d;
      sp_prod2_q <= sp_prod1_q;
      dsd2_q     <= dsd1_q;
      spring2_q  <= spring1_q;
      oob2_q     <= oob1_q;

      prop3_q    <= GAIN_W'(prop_full[PROD_W+FADE_W-1:18]);
      integ3_q   <= integ3_d;
      click3_q   <= GAIN_W'(click_full[DT_W+FADE_W-1:23]);
      cf3_q      <= CF_W'(coef2_q) * CF_W'(fade2_q);
      dsd3_q     <= dsd2_q;
      band3_q    <= band3_d;
      live3_q    <= spring2_q && (fade2_q != '0);
      oob3_q     <= oob2_q;

      gp_q   <= live3_q ? prop3_q : '0;
      gi_q   <= inb4 ? integ3_q : '0;
      gd_q   <= live3_q ? GAIN_W'(deriv_full[PROD_W+CF_W-1:36]) : '0;
      band_q <= inb4 ? band3_q : '0;
      ct_q   <= click_ok ? click3_q : '0;
      cm_q   <= click_ok ? MICROS_W'(CLICK_US) : '0;
    end
  end

  assign rsp_o.valid        = v4_q;
  assign rsp_o.gain_prop    = gp_q;
  assign rsp_o.gain_integ   = gi_q;
  assign rsp_o.gain_deriv   = gd_q;
  assign rsp_o.integ_band   = band_q;
  assign rsp_o.burst_torque = ct_q;
  assign rsp_o.click_micros = cm_q;

  a_valid_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v1_q |=> v2_q)
    else $error("stage 1 request lost on advance");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && v3_q |=> v3_q && $stable(prop3_q) && $stable(live3_q))
    else $error("stage 3 changed during stall");

  a_fade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> fade2_q <= FADE_W'(FADE_ONE))
    else $error("fade above unity");

  a_click_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && cm_q == '0 |-> ct_q == '0)
    else $error("click torque without click duration");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: haptic gain scheduler testbench
// Drives velocity requests through the valid/ready request channel and
// predicts each gain set from a local copy of the detent registers. Every
// result is checked field by field, in order. Directed requests cover the
// speed fade, the flags, the width bands and saturation. Random traffic then
// runs under several register settings with sender and receiver idling, a
// long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_top
  import hgs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FADE_LO       = 2560;
  localparam longint unsigned FADE_HI       = 5120;
  localparam longint unsigned FADE_UNITY    = 65536;
  localparam longint unsigned INTEG_GAIN    = 256;
  localparam longint unsigned WIDTH_STIFF   = 429;
  localparam longint unsigned WIDTH_SOFT    = 1144;
  localparam longint unsigned WIDTH_NOCLICK = 1430;
  localparam longint unsigned DAMP_STIFF    = 5243;
  localparam longint unsigned DAMP_SOFT     = 1311;
  localparam longint unsigned BAND_RATIO    = 19661;
  localparam longint unsigned BAND_CAP      = 429;
  localparam longint unsigned CLICK_LEN_US  = 3000;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int PIPE_DEPTH  = 4;
  localparam int HOLD_CYCLES = 64;
  localparam int CHUNK_ITEMS = 40;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_prop;
    logic [GAIN_W-1:0]   gain_integ;
    logic [GAIN_W-1:0]   gain_deriv;
    logic [BAND_W-1:0]   integ_band;
    logic [GAIN_W-1:0]   burst_torque;
    logic [MICROS_W-1:0] click_micros;
  } gains_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  hgs_in_if  req_if ();
  hgs_out_if rsp_if ();

  haptic_gain_scheduler DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [15:0] detent_str;
  logic [15:0] endstop_str;
  logic [15:0] detent_wid;
  logic        listed_detents;
  logic [15:0] scale_p;
  logic [15:0] scale_i;
  logic [15:0] scale_d;

  gains_t pending_gains[$];
  gains_t got_gains;
  gains_t want_gains;
  int     fail_count   = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  int     holds_asked  = 0;
  int     holds_done   = 0;
  int     hold_left    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] clip32(input longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic gains_t schedule_gains(input logic [VEL_W-1:0] vel, input logic spring,
                                            input logic oob);
    gains_t g;
    longint unsigned speed, fade, s, d, w, coef, taper, t;
    g = '0;
    speed = vel[VEL_W-1] ? 64'd65536 - 64'(vel) : 64'(vel);
    if (speed <= FADE_LO) fade = FADE_UNITY;
    else if (speed >= FADE_HI) fade = 0;
    else fade = ((FADE_HI - speed) * 64'd65536) / (FADE_HI - FADE_LO);
    if (!spring || fade == 0) return g;
    d = 64'(detent_str);
    w = 64'(detent_wid);
    s = oob ? 64'(endstop_str) : d;
    g.gain_prop = clip32((s * 64'd4 * 64'(scale_p) * fade) >> 20);
    if (w <= WIDTH_STIFF) coef = DAMP_STIFF;
    else if (w >= WIDTH_SOFT) coef = DAMP_SOFT;
    else coef = DAMP_STIFF - ((DAMP_STIFF - DAMP_SOFT) * (w - WIDTH_STIFF)) /
                             (WIDTH_SOFT - WIDTH_STIFF);
    g.gain_deriv = clip32((d * coef * 64'(scale_d) * fade) >> 36);
    if (!oob) begin
      t = (d * INTEG_GAIN * 64'(scale_i)) >> 12;
      g.gain_integ = clip32((t * fade) >> 16);
      t = (w * BAND_RATIO) >> 16;
      g.integ_band = (t < BAND_CAP) ? t[15:0] : BAND_CAP[15:0];
      if (!listed_detents && w < WIDTH_NOCLICK) begin
        taper = ((WIDTH_NOCLICK - w) * 64'd65536) / WIDTH_NOCLICK;
        g.burst_torque = clip32((d * 64'd2 * taper * fade) >> 24);
        g.click_micros = CLICK_LEN_US[MICROS_W-1:0];
      end
    end
    return g;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got_gains = '{rsp_if.gain_prop, rsp_if.gain_integ, rsp_if.gain_deriv,
                    rsp_if.integ_band, rsp_if.burst_torque, rsp_if.click_micros};
      if (pending_gains.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want_gains = pending_gains.pop_front();
        compare_field("gain_prop", want_gains.gain_prop, got_gains.gain_prop);
        compare_field("gain_integ", want_gains.gain_integ, got_gains.gain_integ);
        compare_field("gain_deriv", want_gains.gain_deriv, got_gains.gain_deriv);
        compare_field("integ_band", want_gains.integ_band, got_gains.integ_band);
        compare_field("burst_torque", want_gains.burst_torque, got_gains.burst_torque);
        compare_field("click_micros", want_gains.click_micros, got_gains.click_micros);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic push_request(input int vel, input logic spring, input logic oob);
    gains_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    want = schedule_gains(vel[15:0], spring, oob);
    req_if.valid          <= 1'b1;
    req_if.knob_velocity  <= vel[15:0];
    req_if.detent_engaged <= spring;
    req_if.beyond_bounds  <= oob;
    do @(posedge clk); while (!req_if.ready);
    pending_gains.push_back(want);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DETENT_STRENGTH:  detent_str     = data;
      CFG_ENDSTOP_STRENGTH: endstop_str    = data;
      CFG_DETENT_WIDTH:     detent_wid     = data;
      CFG_HAS_LISTED:       listed_detents = data[0];
      CFG_SCALE_PROP:       scale_p        = data;
      CFG_SCALE_INTEG:      scale_i        = data;
      CFG_SCALE_DERIV:      scale_d        = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_settings(input logic [15:0] d, input logic [15:0] e,
                                  input logic [15:0] w, input logic [15:0] listed,
                                  input logic [15:0] sp, input logic [15:0] si,
                                  input logic [15:0] sd);
    drain_results();
    write_reg(CFG_DETENT_STRENGTH, d);
    write_reg(CFG_ENDSTOP_STRENGTH, e);
    write_reg(CFG_DETENT_WIDTH, w);
    write_reg(CFG_HAS_LISTED, listed);
    write_reg(CFG_SCALE_PROP, sp);
    write_reg(CFG_SCALE_INTEG, si);
    write_reg(CFG_SCALE_DERIV, sd);
  endtask

  function automatic logic [15:0] rand_reg();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic int rand_velocity();
    case ($urandom_range(7))
      0, 1:    return $urandom_range(65535);
      2:       return $urandom_range(2600) - 1300 + (($urandom_range(1)) ? 2560 : -2560);
      default: return $urandom_range(10400) - 5200;
    endcase
  endfunction

  task automatic program_random_settings();
    logic [15:0] w;
    w = ($urandom_range(3) != 0) ? 16'($urandom_range(1600)) : rand_reg();
    program_settings(rand_reg(), rand_reg(), w, 16'($urandom_range(65535)),
                     rand_reg(), rand_reg(), rand_reg());
  endtask

  task automatic test_reset_defaults();
    push_request(0, 1'b1, 1'b0);
    push_request(-100, 1'b1, 1'b1);
  endtask

  task automatic test_speed_fade();
    program_settings(16'h4000, 16'h8000, 16'd600, 16'd0, 16'd4096, 16'd4096, 16'd4096);
    push_request(0, 1'b1, 1'b0);
    push_request(2560, 1'b1, 1'b0);
    push_request(2561, 1'b1, 1'b0);
    push_request(-2560, 1'b1, 1'b0);
    push_request(3840, 1'b1, 1'b0);
    push_request(-3841, 1'b1, 1'b0);
    push_request(5119, 1'b1, 1'b0);
    push_request(5120, 1'b1, 1'b0);
    push_request(-5120, 1'b1, 1'b0);
    push_request(32767, 1'b1, 1'b0);
    push_request(-32768, 1'b1, 1'b0);
  endtask

  task automatic test_flags();
    push_request(0, 1'b0, 1'b0);
    push_request(100, 1'b1, 1'b1);
    push_request(-100, 1'b0, 1'b1);
  endtask

  task automatic test_width_bands();
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'd429);
    push_request(10, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'd1000);
    push_request(10, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'd1144);
    push_request(10, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'd1430);
    push_request(10, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'hFFFF);
    push_request(10, 1'b1, 1'b0);
    drain_results();
    write_reg(CFG_DETENT_WIDTH, 16'd0);
    write_reg(CFG_HAS_LISTED, 16'd1);
    write_reg(CFG_NO_REG, 16'hFFFF);
    push_request(10, 1'b1, 1'b0);
  endtask

  task automatic test_saturation();
    program_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(0, 1'b1, 1'b0);
    push_request(0, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    program_random_settings();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    holds_asked <= holds_asked + 1;
    repeat (CHUNK_ITEMS)
      push_request(rand_velocity(), $urandom_range(99) < 85, $urandom_range(99) < 30);
    drain_results();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int chunks);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (chunks) begin
      program_random_settings();
      repeat (CHUNK_ITEMS)
        push_request(rand_velocity(), $urandom_range(99) < 85, $urandom_range(99) < 30);
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_DETENT_STRENGTH;
    cfg_data              <= '0;
    req_if.valid          <= 1'b0;
    req_if.knob_velocity  <= '0;
    req_if.detent_engaged <= 1'b0;
    req_if.beyond_bounds  <= 1'b0;
    detent_str     = 16'd0;
    endstop_str    = 16'd0;
    detent_wid     = 16'd0;
    listed_detents = 1'b0;
    scale_p        = 16'd4096;
    scale_i        = 16'd4096;
    scale_d        = 16'd4096;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_speed_fade();
    test_flags();
    test_width_bands();
    test_saturation();
    test_backpressure();
    test_random_traffic(18, 80, 4);
    test_random_traffic(80, 18, 4);
    program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(0, 0, 4);
    drain_results();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
